// File: rtl/three_stage_charge_controller_top_assert.svh
// Assertion macros for the charge controller checker
`ifndef THREE_STAGE_CHARGE_CONTROLLER_TOP_ASSERT_SVH
`define THREE_STAGE_CHARGE_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tscc assertion failed");

// next-cycle implication, disabled in reset
`define TSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tscc assertion failed");

`endif

// File: rtl/tscc_pkg.sv
// Types, constants and register map of the charge controller
package tscc_pkg;

	localparam int MV_W    = 15;
	localparam int MA_W    = 16;
	localparam int DUTY_W  = 10;
	localparam int STAGE_W = 2;
	localparam int CFG_W   = 15;
	localparam int CFG_IDX_W = 4;

	typedef logic [MV_W-1:0]          mv_t;
	typedef logic signed [MA_W-1:0]   ma_t;
	typedef logic [CFG_W-1:0]         cfg_word_t;
	typedef logic [DUTY_W-1:0]        duty_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	typedef enum logic [STAGE_W-1:0] {
		STAGE_BULK   = 2'd0,
		STAGE_ABSORB = 2'd1,
		STAGE_FLOAT  = 2'd2
	} stage_t;

	localparam cfg_idx_t REG_BULK_LOW      = 4'd0;
	localparam cfg_idx_t REG_BULK_HIGH     = 4'd1;
	localparam cfg_idx_t REG_ABSORB_TARGET = 4'd2;
	localparam cfg_idx_t REG_FLOAT_LOW     = 4'd3;
	localparam cfg_idx_t REG_FLOAT_TARGET  = 4'd4;
	localparam cfg_idx_t REG_BULK_LIMIT    = 4'd5;
	localparam cfg_idx_t REG_ABSORB_LIMIT  = 4'd6;
	localparam cfg_idx_t REG_ABSORB_EXIT   = 4'd7;

	localparam cfg_word_t RST_BULK_LOW      = 15'd13000;
	localparam cfg_word_t RST_BULK_HIGH     = 15'd14500;
	localparam cfg_word_t RST_ABSORB_TARGET = 15'd14700;
	localparam cfg_word_t RST_FLOAT_LOW     = 15'd13200;
	localparam cfg_word_t RST_FLOAT_TARGET  = 15'd13400;
	localparam cfg_word_t RST_BULK_LIMIT    = 15'd2000;
	localparam cfg_word_t RST_ABSORB_LIMIT  = 15'd2000;
	localparam cfg_word_t RST_ABSORB_EXIT   = 15'd200;

	localparam ma_t   FLOAT_EXIT_MA  = 16'sd220;
	localparam mv_t   LOAD_CUTOFF_MV = 15'd9000;
	localparam duty_t DUTY_MAX       = 10'd1023;
	localparam duty_t DUTY_MIN       = 10'd0;

	typedef struct packed {
		cfg_word_t bulk_low_mv;
		cfg_word_t bulk_high_mv;
		cfg_word_t absorb_target_mv;
		cfg_word_t float_low_mv;
		cfg_word_t float_target_mv;
		cfg_word_t bulk_limit_ma;
		cfg_word_t absorb_limit_ma;
		cfg_word_t absorb_exit_ma;
	} cfg_t;

	typedef struct packed {
		stage_t stage;
		duty_t  duty;
	} chg_state_t;

endpackage

// File: rtl/tscc_if.sv
// Valid/ready channels for sample and result words
interface tscc_in_if;
	import tscc_pkg::*;
	logic valid;
	logic ready;
	mv_t  battery_mv;
	ma_t  solar_ma;
	modport source (output valid, battery_mv, solar_ma, input ready);
	modport sink   (input valid, battery_mv, solar_ma, output ready);
endinterface

interface tscc_out_if;
	import tscc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [DUTY_W-1:0]    duty;
	logic [STAGE_W-1:0]   stage;
	logic                 load_on;
	modport source (output valid, duty, stage, load_on, input ready);
	modport sink   (input valid, duty, stage, load_on, output ready);
endinterface

// File: rtl/three_stage_charge_controller_top.sv
// Three-stage charge controller: sample register, step logic, result register
// A sample word is held in the sample register, then loads the result register.
// Throughput: one word per cycle while the output is not stalled; the stage and
// duty registers are the result register, so consecutive samples chain directly.
// Reset: stage goes to bulk, duty to zero, thresholds to their defaults,
// both pipeline stages empty.
module three_stage_charge_controller_top (
	input  logic                clk,
	input  logic                arst_n,
	tscc_in_if.sink             sample,
	tscc_out_if.source          result,
	input  logic                cfg_we,
	input  tscc_pkg::cfg_idx_t  cfg_idx,
	input  tscc_pkg::cfg_word_t cfg_data
);
	import tscc_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	mv_t        mv_s1;
	ma_t        ma_s1;
	logic       valid_s2;
	logic       load_s2;
	chg_state_t state_q;
	chg_state_t state_nxt;
	logic       load_nxt;
	logic       advance;

	tscc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	tscc_step u_step (
		.cfg        (cfg),
		.cur        (state_q),
		.battery_mv (mv_s1),
		.solar_ma   (ma_s1),
		.nxt        (state_nxt),
		.load_on    (load_nxt)
	);

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			mv_s1 <= sample.battery_mv;
			ma_s1 <= sample.solar_ma;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			state_q.stage <= STAGE_BULK;
			state_q.duty  <= DUTY_MIN;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			state_q  <= state_nxt;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) load_s2 <= load_nxt;
	end

	// state register supplies duty and stage of the result payload; load_on has its own register
	assign result.valid   = valid_s2;
	assign result.duty    = state_q.duty;
	assign result.stage   = state_q.stage;
	assign result.load_on = load_s2;

endmodule

// File: rtl/tscc_cfg.sv
// Threshold register file with write port
module tscc_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  tscc_pkg::cfg_idx_t cfg_idx,
	input  tscc_pkg::cfg_word_t cfg_data,
	output tscc_pkg::cfg_t     cfg
);
	import tscc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bulk_low_mv      <= RST_BULK_LOW;
			cfg_q.bulk_high_mv     <= RST_BULK_HIGH;
			cfg_q.absorb_target_mv <= RST_ABSORB_TARGET;
			cfg_q.float_low_mv     <= RST_FLOAT_LOW;
			cfg_q.float_target_mv  <= RST_FLOAT_TARGET;
			cfg_q.bulk_limit_ma    <= RST_BULK_LIMIT;
			cfg_q.absorb_limit_ma  <= RST_ABSORB_LIMIT;
			cfg_q.absorb_exit_ma   <= RST_ABSORB_EXIT;
		end else if (cfg_we) begin
			// indices past the map are dropped
			unique case (cfg_idx)
				REG_BULK_LOW:      cfg_q.bulk_low_mv      <= cfg_data;
				REG_BULK_HIGH:     cfg_q.bulk_high_mv     <= cfg_data;
				REG_ABSORB_TARGET: cfg_q.absorb_target_mv <= cfg_data;
				REG_FLOAT_LOW:     cfg_q.float_low_mv     <= cfg_data;
				REG_FLOAT_TARGET:  cfg_q.float_target_mv  <= cfg_data;
				REG_BULK_LIMIT:    cfg_q.bulk_limit_ma    <= cfg_data;
				REG_ABSORB_LIMIT:  cfg_q.absorb_limit_ma  <= cfg_data;
				REG_ABSORB_EXIT:   cfg_q.absorb_exit_ma   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/tscc_step.sv
// Next-stage and duty step logic for one sample
module tscc_step (
	input  tscc_pkg::cfg_t       cfg,
	input  tscc_pkg::chg_state_t cur,
	input  tscc_pkg::mv_t        battery_mv,
	input  tscc_pkg::ma_t        solar_ma,
	output tscc_pkg::chg_state_t nxt,
	output logic                 load_on
);
	import tscc_pkg::*;

	logic   dn;
	logic   up;
	stage_t st;

	// unsigned limits widened to signed, so negative current is below all
	function automatic ma_t as_ma(input cfg_word_t w);
		as_ma = signed'({1'b0, w});
	endfunction

	assign load_on = (battery_mv >= LOAD_CUTOFF_MV);

	always_comb begin
		dn = 1'b0;
		up = 1'b0;
		st = cur.stage;
		if (cur.stage == STAGE_FLOAT) begin
			if (battery_mv < cfg.float_low_mv) begin
				st = STAGE_BULK;
			end else if (solar_ma > FLOAT_EXIT_MA) begin
				st = STAGE_BULK;
			end else if (battery_mv > cfg.float_target_mv) begin
				dn = 1'b1;
			end else begin
				up = 1'b1;
			end
		end else begin
			if (battery_mv < cfg.bulk_low_mv) begin
				st = STAGE_BULK;
			end else if (battery_mv > cfg.bulk_high_mv) begin
				st = STAGE_ABSORB;
			end
			unique case (st)
				STAGE_BULK: begin
					if (solar_ma > as_ma(cfg.bulk_limit_ma)) dn = 1'b1;
					else up = 1'b1;
				end
				STAGE_ABSORB: begin
					if (solar_ma > as_ma(cfg.absorb_limit_ma)) begin
						dn = 1'b1;
					end else begin
						if (battery_mv > cfg.absorb_target_mv) dn = 1'b1;
						else up = 1'b1;
						if (solar_ma < as_ma(cfg.absorb_exit_ma)) st = STAGE_FLOAT;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		nxt.stage = st;
		nxt.duty  = cur.duty;
		if (up && (cur.duty != DUTY_MAX)) nxt.duty = cur.duty + 10'd1;
		else if (dn && (cur.duty != DUTY_MIN)) nxt.duty = cur.duty - 10'd1;
	end

endmodule

// File: rtl/tscc_checker.sv
// Port-level checker for the charge controller and its bind
`include "three_stage_charge_controller_top_assert.svh"

module tscc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] duty,
	input logic [1:0] stage,
	input logic       load_on
);
	import tscc_pkg::*;

	logic stall;
	assign stall = out_valid && !out_ready;

	`TSCC_ASSERT_IMP(a_stage_code, clk, arst_n, out_valid, stage != 2'd3)
	`TSCC_ASSERT_NXT(a_word_emerges, clk, arst_n, in_valid && in_ready, ##1 out_valid)
	`TSCC_ASSERT_NXT(a_valid_holds, clk, arst_n, stall, out_valid)
	`TSCC_ASSERT_NXT(a_payload_holds, clk, arst_n, stall, $stable(duty) && $stable(stage) && $stable(load_on))

endmodule

bind three_stage_charge_controller_top tscc_checker u_tscc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.duty      (result.duty),
	.stage     (result.stage),
	.load_on   (result.load_on)
);

// File: test/three_stage_charge_controller_top_tb.sv
// Self-checking bench for the three-stage charge controller: directed table, then random samples
module three_stage_charge_controller_top_tb;
	import tscc_pkg::*;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SQUEEZE_CYCLES   = 200;
	localparam int CLIMB_WORDS      = 250;
	localparam int WORDS_PER_PHASE  = 54;
	localparam int N_PHASES         = 7;
	localparam int N_DIRECTED       = 23;
	localparam int MV_TOP           = 32000;
	localparam int MA_TOP           = 32767;
	localparam int MA_BOTTOM        = -32768;

	typedef struct packed {
		duty_t  duty;
		stage_t stage;
		logic   load_on;
	} charge_word_t;

	typedef struct packed {
		mv_t          mv;
		ma_t          ma;
		logic         pinned;
		charge_word_t want;
	} sample_row_t;

	// pinned rows carry their result, the rest go through the predictor
	localparam sample_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{15'd0,     16'sd0,     1'b1, '{10'd1, STAGE_BULK, 1'b0}},
		'{15'd8999,  16'sd32767, 1'b1, '{10'd0, STAGE_BULK, 1'b0}},
		'{15'd0,     16'sd32767, 1'b1, '{10'd0, STAGE_BULK, 1'b0}},
		'{15'd9000,  16'sh8000,  1'b1, '{10'd1, STAGE_BULK, 1'b1}},
		'{15'd12999, 16'sd2000,  1'b0, '0},
		'{15'd14500, 16'sd2001,  1'b0, '0},
		'{15'd32000, 16'sd2000,  1'b0, '0},
		'{15'd14700, 16'sd2001,  1'b0, '0},
		'{15'd14700, 16'sd200,   1'b0, '0},
		'{15'd14501, 16'sd199,   1'b0, '0},
		'{15'd13400, 16'sd220,   1'b0, '0},
		'{15'd13401, 16'sh8000,  1'b0, '0},
		'{15'd13200, 16'sd0,     1'b0, '0},
		'{15'd13199, 16'sd0,     1'b0, '0},
		'{15'd13000, 16'sd0,     1'b0, '0},
		'{15'd15000, -16'sd1,    1'b0, '0},
		'{15'd20000, 16'sd221,   1'b0, '0},
		'{15'd15000, 16'sd100,   1'b0, '0},
		'{15'd32000, 16'sd32767, 1'b0, '0},
		'{15'd14000, 16'sd2000,  1'b0, '0},
		'{15'd14501, 16'sd32767, 1'b0, '0},
		'{15'd13500, 16'sd0,     1'b0, '0},
		'{15'd12000, 16'sd0,     1'b0, '0}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we;
	cfg_idx_t  cfg_idx;
	cfg_word_t cfg_data;

	tscc_in_if  sample_ch();
	tscc_out_if result_ch();

	three_stage_charge_controller_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	cfg_t         thr;
	stage_t       stage_now;
	duty_t        duty_now;
	sample_row_t  offered_rows [$];
	charge_word_t due_results [$];

	int mismatches = 0;
	int checked = 0;
	int floats_seen = 0;
	int top_hits = 0;
	int bottom_hits = 0;
	int settings = 1;
	int idle_cycles = 0;
	int quiet_sends = 0;
	int run_left = 0;
	int mv_focus = 0;
	int ma_focus = 0;
	int focus_span = 3;
	bit squeeze = 1'b0;
	bit calm = 1'b0;

	function automatic duty_t nudge(duty_t d, logic raise);
		if (raise)
			return (d == DUTY_MAX) ? d : d + 1'b1;
		return (d == DUTY_MIN) ? d : d - 1'b1;
	endfunction

	function automatic void set_threshold(cfg_idx_t idx, cfg_word_t val);
		case (idx)
			REG_BULK_LOW:      thr.bulk_low_mv      = val;
			REG_BULK_HIGH:     thr.bulk_high_mv     = val;
			REG_ABSORB_TARGET: thr.absorb_target_mv = val;
			REG_FLOAT_LOW:     thr.float_low_mv     = val;
			REG_FLOAT_TARGET:  thr.float_target_mv  = val;
			REG_BULK_LIMIT:    thr.bulk_limit_ma    = val;
			REG_ABSORB_LIMIT:  thr.absorb_limit_ma  = val;
			REG_ABSORB_EXIT:   thr.absorb_exit_ma   = val;
			default: ;
		endcase
	endfunction

	// one sample through the stage machine; currents compare signed against the limits
	function automatic charge_word_t charge_step(mv_t mv, ma_t ma);
		int           amps;
		charge_word_t w;
		amps = int'(ma);
		w.load_on = (mv >= LOAD_CUTOFF_MV);
		if (stage_now == STAGE_FLOAT) begin
			if (mv < thr.float_low_mv || amps > int'(FLOAT_EXIT_MA))
				stage_now = STAGE_BULK;
			else
				duty_now = nudge(duty_now, !(mv > thr.float_target_mv));
		end else begin
			if (mv < thr.bulk_low_mv)
				stage_now = STAGE_BULK;
			else if (mv > thr.bulk_high_mv)
				stage_now = STAGE_ABSORB;
			if (stage_now == STAGE_BULK) begin
				duty_now = nudge(duty_now, !(amps > int'(thr.bulk_limit_ma)));
			end else if (stage_now == STAGE_ABSORB) begin
				if (amps > int'(thr.absorb_limit_ma)) begin
					duty_now = nudge(duty_now, 1'b0);
				end else begin
					duty_now = nudge(duty_now, !(mv > thr.absorb_target_mv));
					if (amps < int'(thr.absorb_exit_ma))
						stage_now = STAGE_FLOAT;
				end
			end
		end
		w.duty = duty_now;
		w.stage = stage_now;
		return w;
	endfunction

	function automatic int near(int mark, int lo, int hi, int span);
		int v;
		v = mark + int'($urandom_range(0, 2 * span)) - span;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	function automatic sample_row_t any_sample();
		sample_row_t row;
		row = '0;
		row.mv = mv_t'($urandom_range(0, MV_TOP));
		row.ma = ma_t'($urandom_range(0, 16'hFFFF));
		return row;
	endfunction

	// runs of samples hover round one voltage and one current threshold
	function automatic sample_row_t shaped_sample();
		sample_row_t row;
		int          mv_marks [5];
		int          ma_marks [5];
		mv_marks = '{int'(thr.bulk_low_mv), int'(thr.bulk_high_mv), int'(thr.absorb_target_mv),
			int'(thr.float_low_mv), int'(thr.float_target_mv)};
		ma_marks = '{int'(thr.bulk_limit_ma), int'(thr.absorb_limit_ma),
			int'(thr.absorb_exit_ma), int'(FLOAT_EXIT_MA), 0};
		if (run_left == 0) begin
			run_left = $urandom_range(1, 8);
			mv_focus = $urandom_range(0, 4);
			ma_focus = $urandom_range(0, 4);
			focus_span = ($urandom_range(0, 3) == 0) ? 400 : 3;
		end
		run_left--;
		row = any_sample();
		if ($urandom_range(0, 99) < 80)
			row.mv = mv_t'(near(mv_marks[mv_focus], 0, MV_TOP, focus_span));
		if ($urandom_range(0, 99) < 80)
			row.ma = ma_t'(near(ma_marks[ma_focus], MA_BOTTOM, MA_TOP, focus_span));
		return row;
	endfunction

	task automatic offer(sample_row_t row);
		if (quiet_sends > 0) begin
			quiet_sends--;
		end else if ($urandom_range(0, 99) < 3) begin
			quiet_sends = $urandom_range(20, 60);
		end else if (!calm && !squeeze && $urandom_range(0, 99) < 10) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		offered_rows.push_back(row);
		sample_ch.valid <= 1'b1;
		sample_ch.battery_mv <= row.mv;
		sample_ch.solar_ma <= row.ma;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic park();
		sample_ch.valid <= 1'b0;
		while (offered_rows.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// all eight thresholds, then one write to an unmapped index
	task automatic load_thresholds(input cfg_word_t vals [8]);
		for (cfg_idx_t r = REG_BULK_LOW; r <= REG_ABSORB_EXIT; r++) begin
			cfg_we <= 1'b1;
			cfg_idx <= r;
			cfg_data <= vals[r];
			@(posedge clk);
			set_threshold(r, vals[r]);
		end
		cfg_idx <= cfg_idx_t'(REG_ABSORB_EXIT + 1 + $urandom_range(0, 7));
		cfg_data <= cfg_word_t'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	always @(posedge clk) begin : scoreboard
		sample_row_t  row;
		charge_word_t guess;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				row = (offered_rows.size() != 0) ? offered_rows.pop_front() : '0;
				guess = charge_step(sample_ch.battery_mv, sample_ch.solar_ma);
				due_results.push_back(row.pinned ? row.want : guess);
			end
			if (result_ch.valid && result_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result word with nothing outstanding");
					mismatches++;
				end else begin
					guess = due_results.pop_front();
					checked++;
					if (guess.stage == STAGE_FLOAT)
						floats_seen++;
					if (guess.duty == DUTY_MAX)
						top_hits++;
					if (guess.duty == DUTY_MIN)
						bottom_hits++;
					if (result_ch.duty !== guess.duty) begin
						$error("duty: expected %0d, got %0d", guess.duty, result_ch.duty);
						mismatches++;
					end
					if (result_ch.stage !== guess.stage) begin
						$error("stage: expected %0d, got %0d", guess.stage, result_ch.stage);
						mismatches++;
					end
					if (result_ch.load_on !== guess.load_on) begin
						$error("load_on: expected %0d, got %0d", guess.load_on,
							result_ch.load_on);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : receiver
		int quiet;
		quiet = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze) begin
				result_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze = 1'b0;
			end else if (quiet > 0) begin
				quiet--;
			end else if (!calm && $urandom_range(0, 99) < 3) begin
				quiet = $urandom_range(20, 80);
			end else if (!calm && $urandom_range(0, 99) < 10) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	initial begin : stimulus
		cfg_word_t plan [8];
		sample_ch.valid <= 1'b0;
		sample_ch.battery_mv <= '0;
		sample_ch.solar_ma <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_BULK_LOW;
		cfg_data <= '0;
		thr = '{RST_BULK_LOW, RST_BULK_HIGH, RST_ABSORB_TARGET, RST_FLOAT_LOW,
			RST_FLOAT_TARGET, RST_BULK_LIMIT, RST_ABSORB_LIMIT, RST_ABSORB_EXIT};
		stage_now = STAGE_BULK;
		duty_now = DUTY_MIN;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			offer(DIRECTED_ROWS[i]);

		// bulk with no effective limit: duty climbs steadily
		park();
		plan = '{15'd32000, 15'd32000, 15'd32000, 15'd0, 15'd0, 15'd32767, 15'd32767, 15'd0};
		load_thresholds(plan);
		repeat (CLIMB_WORDS)
			offer(any_sample());

		for (int p = 0; p < N_PHASES; p++) begin
			park();
			case (p)
				0: plan = '{default: 15'd0};
				2: plan = '{15'd32000, 15'd32000, 15'd32000, 15'd32000, 15'd32000,
					15'd32767, 15'd32767, 15'd32767};
				3: plan = '{15'd15000, 15'd12000, 15'd11000, 15'd14000, 15'd12500,
					15'd100, 15'd50, 15'd3000};
				4, 5: begin
					for (int r = 0; r < 5; r++)
						plan[r] = cfg_word_t'($urandom_range(0, MV_TOP));
					for (int r = 5; r < 8; r++)
						plan[r] = cfg_word_t'($urandom_range(0, MA_TOP));
				end
				default: plan = '{RST_BULK_LOW, RST_BULK_HIGH, RST_ABSORB_TARGET,
					RST_FLOAT_LOW, RST_FLOAT_TARGET, RST_BULK_LIMIT, RST_ABSORB_LIMIT,
					RST_ABSORB_EXIT};
			endcase
			load_thresholds(plan);
			if (p == 1)
				squeeze = 1'b1;
			if (p == N_PHASES - 1)
				calm = 1'b1;
			repeat (WORDS_PER_PHASE)
				offer(shaped_sample());
		end

		park();
		@(negedge clk);
		$display("%0d result words checked over %0d threshold settings, incl. a long output stall",
			checked, settings);
		$display("float on %0d words, duty at full scale %0d and at zero %0d times",
			floats_seen, top_hits, bottom_hits);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
